/* rtl/tks_pkg.sv */
package tks_pkg;

  // Key count range and the default
  localparam int KEY_COUNT_DEF = 9;
  localparam int KEY_COUNT_MAX = 16;

  // Field widths
  localparam int KEY_IDX_W = 4;   // index of a key, 0..15
  localparam int KEY_NUM_W = 5;   // key number, 1..16
  localparam int CODE_W    = 4;   // key_code field
  localparam int TOUCH_W   = 9;   // touch_value field
  localparam int WORD_W    = 16;  // scanned data word
  localparam int BYTE_W    = 8;

  // key_code_mode values
  localparam logic MODE_ONE_HOT = 1'b0;
  localparam logic MODE_INDEX   = 1'b1;

  // Result of one key scan
  typedef struct packed {
    logic                  hit;     // a newly pressed key was found
    logic [KEY_NUM_W-1:0]  number;  // key index + 1
    logic [TOUCH_W-1:0]    value;   // touch value for the current mode
  } key_hit_t;

  // Bit position of each key in the data word, in priority order
  function automatic logic [KEY_IDX_W-1:0] key_bit_pos(input logic [KEY_IDX_W-1:0] idx);
    logic [KEY_IDX_W-1:0] pos;
    case (idx)
      4'd0:    pos = 4'd15;
      4'd1:    pos = 4'd14;
      4'd2:    pos = 4'd13;
      4'd3:    pos = 4'd0;
      4'd4:    pos = 4'd1;
      4'd5:    pos = 4'd12;
      4'd6:    pos = 4'd2;
      4'd7:    pos = 4'd3;
      4'd8:    pos = 4'd4;
      4'd9:    pos = 4'd5;
      4'd10:   pos = 4'd6;
      4'd11:   pos = 4'd7;
      4'd12:   pos = 4'd8;
      4'd13:   pos = 4'd9;
      4'd14:   pos = 4'd10;
      default: pos = 4'd11;
    endcase
    return pos;
  endfunction

endpackage

/* rtl/tks_key_scan.sv */
module tks_key_scan #(
  parameter int KEY_COUNT = tks_pkg::KEY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          scan_en,
  input  logic                          mode,
  input  logic [tks_pkg::WORD_W-1:0]    word,
  output tks_pkg::key_hit_t             hit
);
  import tks_pkg::*;

  logic [KEY_COUNT-1:0] latch_r;
  logic [KEY_COUNT-1:0] latch_nxt;
  logic [KEY_IDX_W-1:0] idx;
  logic                 found;

  // Walk the keys in priority order; released keys clear their latch,
  // the first fresh press sets its latch and ends the walk.
  always_comb begin
    latch_nxt = latch_r;
    found     = 1'b0;
    idx       = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (!found) begin
        if (word[key_bit_pos(KEY_IDX_W'(i))]) begin
          latch_nxt[i] = 1'b0;
        end else if (!latch_r[i]) begin
          latch_nxt[i] = 1'b1;
          found        = 1'b1;
          idx          = KEY_IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    hit.hit    = found;
    hit.number = KEY_NUM_W'(idx) + KEY_NUM_W'(1);
    if (mode == MODE_INDEX) begin
      hit.value = TOUCH_W'(hit.number);
    end else begin
      hit.value = TOUCH_W'(1) << idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else if (scan_en) begin
      latch_r <= latch_nxt;
    end
  end

endmodule

/* rtl/i2c_touch_key_scanner.sv */
// I2C touch key scanner. Every input word is one half-bit tick of the bus and
// yields exactly one output word carrying the SCL/SDA levels to drive for that
// tick plus status. A start request seen while idle launches a 58-tick read:
// start condition, the address byte from device_address_byte (captured at
// start), a device acknowledge sample, two data bytes (first = low byte) with
// a master ACK after the first and a NACK after the second, then a stop. On
// the stop tick the 16-bit word is scanned for nine active-low keys; the first
// newly pressed key raises key_event with its number in key_code, and
// touch_value keeps the last key as one-hot or index per key_code_mode.
// Throughput is one word per clock while the output is not stalled: the
// next-state logic sits between the sequencer registers and a single output
// register, and in_tready only drops while a finished output word is held by
// backpressure. Write configuration only while the bus is idle.
module i2c_touch_key_scanner #(
  parameter int KEY_COUNT = tks_pkg::KEY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_read, [1] sda_level, [7:2] zero
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] scl_level, [1] sda_released,
                                  // [2] busy_res, [3] key_event,
                                  // [7:4] key_code, [16:8] touch_value,
                                  // [17] ack_missing, [23:18] zero
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import tks_pkg::*;

  // Register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ADDR = 1'b1;
  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h81;

  // Tick schedule
  localparam int PH_W = 7;
  localparam logic [PH_W-1:0] PH_IDLE  = 7'd0;
  localparam logic [PH_W-1:0] PH_START = 7'd1;
  localparam logic [PH_W-1:0] PH_ADDR  = 7'd2;
  localparam logic [PH_W-1:0] PH_DACK  = 7'd18;
  localparam logic [PH_W-1:0] PH_BYTE1 = 7'd20;
  localparam logic [PH_W-1:0] PH_MACK  = 7'd36;
  localparam logic [PH_W-1:0] PH_BYTE2 = 7'd38;
  localparam logic [PH_W-1:0] PH_NACK  = 7'd54;
  localparam logic [PH_W-1:0] PH_STOP0 = 7'd56;
  localparam logic [PH_W-1:0] PH_STOP1 = 7'd57;
  localparam logic [PH_W-1:0] PH_STOP2 = 7'd58;

  // Configuration
  logic              mode_r;
  logic [BYTE_W-1:0] addr_r;

  // Sequencer state
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic               missed_r, missed_nxt;
  logic [TOUCH_W-1:0] touch_r, touch_nxt;

  // Output register
  logic        out_valid_r;
  logic [23:0] out_data_r;

  logic       in_fire;
  logic       start_read;
  logic       sda_in;
  logic       scl;
  logic       sda;
  logic       busy;
  logic       key_ev;
  logic [CODE_W-1:0] key_code;
  logic       scan_en;
  key_hit_t   hit;

  assign start_read = in_tdata[0];
  assign sda_in     = in_tdata[1];

  // Take a new tick whenever the output slot is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Advance the schedule one tick and work out the bus levels for it.
  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    low_nxt    = low_r;
    missed_nxt = missed_r;
    touch_nxt  = touch_r;
    scl        = 1'b1;
    sda        = 1'b1;
    busy       = 1'b0;
    key_ev     = 1'b0;
    key_code   = '0;
    scan_en    = 1'b0;

    if ((phase_r == PH_IDLE) || (phase_r > PH_STOP2)) begin
      phase_nxt = PH_IDLE;
      if (start_read) begin
        phase_nxt  = PH_START;
        shift_nxt  = addr_r;
        missed_nxt = 1'b0;
      end
    end else begin
      phase_nxt = phase_r + PH_W'(1);
    end

    if (phase_nxt != PH_IDLE) begin
      busy = 1'b1;
      if (phase_nxt == PH_START) begin
        sda = 1'b0;
      end else if (phase_nxt inside {[PH_ADDR:PH_DACK - 7'd1]}) begin
        // address bits, MSB first; shift on the high half
        scl = phase_nxt[0];
        sda = shift_r[BYTE_W-1];
        if (phase_nxt[0]) begin
          shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
        end
      end else if (phase_nxt inside {[PH_DACK:PH_BYTE1 - 7'd1]}) begin
        scl = phase_nxt[0];
        if (phase_nxt[0]) begin
          missed_nxt = sda_in;
        end
      end else if (phase_nxt inside {[PH_BYTE1:PH_MACK - 7'd1]}) begin
        scl = phase_nxt[0];
        if (phase_nxt[0]) begin
          shift_nxt = {shift_r[BYTE_W-2:0], sda_in};
        end
        // hold the first byte once its last bit is in
        if (phase_nxt == PH_MACK - 7'd1) begin
          low_nxt = shift_nxt;
        end
      end else if (phase_nxt inside {[PH_MACK:PH_BYTE2 - 7'd1]}) begin
        scl = phase_nxt[0];
        sda = 1'b0;
      end else if (phase_nxt inside {[PH_BYTE2:PH_NACK - 7'd1]}) begin
        scl = phase_nxt[0];
        if (phase_nxt[0]) begin
          shift_nxt = {shift_r[BYTE_W-2:0], sda_in};
        end
      end else if (phase_nxt inside {[PH_NACK:PH_STOP0 - 7'd1]}) begin
        scl = phase_nxt[0];
      end else if (phase_nxt == PH_STOP0) begin
        scl = 1'b0;
        sda = 1'b0;
      end else if (phase_nxt == PH_STOP1) begin
        sda = 1'b0;
      end else begin
        // stop: release SDA, scan the keys, drop back to idle
        scan_en   = in_fire;
        key_ev    = hit.hit;
        if (hit.hit) begin
          key_code  = hit.number[CODE_W-1:0];
          touch_nxt = hit.value;
        end
        phase_nxt = PH_IDLE;
      end
    end
  end

  tks_key_scan #(
    .KEY_COUNT (KEY_COUNT)
  ) u_key_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan_en (scan_en),
    .mode    (mode_r),
    .word    ({shift_r, low_r}),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ONE_HOT;
      addr_r <= ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_wdata[0];
        REG_ADDR: addr_r <= cfg_wdata;
        default:  mode_r <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shift_r  <= '0;
      low_r    <= '0;
      missed_r <= 1'b0;
      touch_r  <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      low_r    <= low_nxt;
      missed_r <= missed_nxt;
      touch_r  <= touch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {6'd0, missed_nxt, touch_nxt, key_code, key_ev, busy, sda, scl};
    end
  end

  // The schedule never runs past the stop tick.
  assert property (@(posedge clk) disable iff (!rst_n) phase_r <= PH_STOP2)
    else $error("phase beyond stop tick");

  // A start request taken while idle enters the start tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_IDLE) && start_read |=> phase_r == PH_START)
    else $error("start request not taken");

  // A key event only appears on the stop tick: busy, SCL high, SDA released.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[3] |-> out_data_r[2:0] == 3'b111)
    else $error("key event outside stop tick");

  // No key code without an event.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[3] |-> out_data_r[7:4] == 4'd0)
    else $error("key code without event");

endmodule

/* tb/testbench.sv */
module testbench;
  import tks_pkg::*;

  // Tick schedule of one read, as phase numbers
  localparam int PH_START = 1;
  localparam int PH_DACK  = 18;
  localparam int PH_BYTE1 = 20;
  localparam int PH_MACK  = 36;
  localparam int PH_BYTE2 = 38;
  localparam int PH_NACK  = 54;
  localparam int PH_STOP0 = 56;
  localparam int PH_STOP1 = 57;
  localparam int PH_STOP2 = 58;

  // Configuration register indexes
  localparam logic REG_KEY_MODE = 1'b0;
  localparam logic REG_DEV_ADDR = 1'b1;

  localparam int KEY_COUNT = KEY_COUNT_DEF;
  // Data word bit of each key, highest priority first
  localparam int KEY_POS [KEY_COUNT_MAX] =
    '{15, 14, 13, 0, 1, 12, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11};

  localparam int TOTAL_TICKS    = 1450;
  localparam int STEADY_FROM    = 600;   // no idling on either side in this window
  localparam int STEADY_TO      = 900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRINT_LIMIT    = 50;

  // One output word, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic [5:0]         pad;
    logic               ack_missing;
    logic [TOUCH_W-1:0] touch;
    logic [CODE_W-1:0]  key_code;
    logic               key_event;
    logic               busy;
    logic               sda;
    logic               scl;
  } tick_result_t;

  typedef enum logic {ROW_IDLE, ROW_READ} row_kind_t;

  // One directed step: an idle tick or a whole read
  typedef struct packed {
    row_kind_t          kind;
    logic               set_cfg;      // write both registers first
    logic               mode;
    logic [7:0]         addr;
    logic               sda_bit;      // device ack level, or SDA of an idle tick
    logic [15:0]        data;         // word the device returns, second byte high
    logic               start_noise;  // toggle start_read while busy
    logic               typed;        // stop tick (or idle tick) fields given below
    logic [CODE_W-1:0]  t_code;
    logic [TOUCH_W-1:0] t_touch;
    logic               t_ack;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 15;
  dir_row_t plan [DIRECTED_ROWS] = '{
    // idle right after reset: lines released, nothing latched
    '{ROW_IDLE, 1'b0, 1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b1, 4'd0, 9'h000, 1'b0},
    '{ROW_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 4'd0, 9'h000, 1'b0},
    // all keys released
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'hFFFF, 1'b0, 1'b1, 4'd0, 9'h000, 1'b0},
    // first key pressed, then held: reported once only
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'h7FFF, 1'b0, 1'b1, 4'd1, 9'h001, 1'b0},
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'h7FFF, 1'b0, 1'b1, 4'd0, 9'h001, 1'b0},
    // all pressed, first one latched; device leaves its ack out
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b1, 4'd2, 9'h002, 1'b1},
    // start requests while busy must be dropped; ack flag clears on the new start
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, 1'b1, 4'd3, 9'h004, 1'b0},
    // index mode, top address: a release keeps the last value
    '{ROW_READ, 1'b1, 1'b1, 8'hFF, 1'b0, 16'hFFFF, 1'b0, 1'b1, 4'd0, 9'h004, 1'b0},
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'hFFEF, 1'b0, 1'b1, 4'd9, 9'h009, 1'b0},
    // one-hot mode, zero address
    '{ROW_READ, 1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1, 4'd1, 9'h001, 1'b0},
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'hFFFF, 1'b0, 1'b0, 4'd0, 9'h000, 1'b0},
    // last key alone: top bit of the one-hot value
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b0, 16'hFFEF, 1'b0, 1'b1, 4'd9, 9'h100, 1'b0},
    '{ROW_READ, 1'b0, 1'b0, 8'h00, 1'b1, 16'hA5C3, 1'b1, 1'b0, 4'd0, 9'h000, 1'b0},
    '{ROW_READ, 1'b1, 1'b1, 8'h81, 1'b0, 16'h0000, 1'b0, 1'b0, 4'd0, 9'h000, 1'b0},
    '{ROW_IDLE, 1'b0, 1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0, 9'h000, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] start_read, [1] sda_level
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [0] scl, [1] sda_released, [2] busy, [3] key_event,
                           // [7:4] key_code, [16:8] touch_value, [17] ack_missing
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  i2c_touch_key_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted bus state and registers
  int                     bus_phase = 0;
  logic [7:0]             bit_shift = '0;
  logic [7:0]             low_data  = '0;
  logic [KEY_COUNT_MAX-1:0] key_held = '0;
  logic [TOUCH_W-1:0]     touch_now = '0;
  logic                   addr_nack = 1'b0;
  logic                   key_mode  = MODE_ONE_HOT;
  logic [7:0]             dev_addr  = 8'h81;

  tick_result_t bus_results_due [$];
  int           mismatch_count = 0;
  int           ticks_sent     = 0;
  int           quiet_cycles   = 0;
  logic         steady         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch on %s: got 'h%0h, want 'h%0h", what, got, want);
    mismatch_count++;
  endtask

  // Advance the predicted bus by one half-bit tick and return its output word
  function automatic tick_result_t predict_bus_tick(input logic start_req,
                                                    input logic sda_in);
    tick_result_t r;
    int           ph;
    int           k;
    logic [15:0]  data;
    logic         found;
    r     = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    found = 1'b0;
    ph    = bus_phase;
    if (ph == 0 || ph > PH_STOP2) begin
      ph = 0;
      if (start_req) begin
        ph        = PH_START;
        bit_shift = dev_addr;
        addr_nack = 1'b0;
      end
    end else begin
      ph = ph + 1;
    end
    if (ph != 0) begin
      r.busy = 1'b1;
      // every two-tick bit slot starts on an even phase: odd phase is SCL high
      if (ph == PH_START) begin
        r.sda = 1'b0;
      end else if (ph < PH_DACK) begin
        r.scl = ph[0];
        r.sda = bit_shift[7];
        if (r.scl) bit_shift = bit_shift << 1;
      end else if (ph < PH_BYTE1) begin
        r.scl = ph[0];
        if (r.scl) addr_nack = sda_in;
      end else if (ph < PH_MACK) begin
        r.scl = ph[0];
        if (r.scl) bit_shift = {bit_shift[6:0], sda_in};
        if (ph == PH_MACK - 1) low_data = bit_shift;
      end else if (ph < PH_BYTE2) begin
        r.scl = ph[0];
        r.sda = 1'b0;
      end else if (ph < PH_NACK) begin
        r.scl = ph[0];
        if (r.scl) bit_shift = {bit_shift[6:0], sda_in};
      end else if (ph < PH_STOP0) begin
        r.scl = ph[0];
      end else if (ph == PH_STOP0) begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end else if (ph == PH_STOP1) begin
        r.sda = 1'b0;
      end else begin
        // stop: scan keys in priority order, released ones drop their latch
        data = {bit_shift, low_data};
        for (k = 0; k < KEY_COUNT && !found; k++) begin
          if (data[KEY_POS[k]]) begin
            key_held[k] = 1'b0;
          end else if (!key_held[k]) begin
            key_held[k] = 1'b1;
            found       = 1'b1;
            touch_now   = (key_mode == MODE_INDEX) ? TOUCH_W'(k + 1) : TOUCH_W'(1 << k);
            r.key_event = 1'b1;
            r.key_code  = CODE_W'(k + 1);
          end
        end
        ph = 0;
      end
    end
    bus_phase     = ph;
    r.touch       = touch_now;
    r.ack_missing = addr_nack;
    return r;
  endfunction

  // Replace the fields that a directed row spells out
  function automatic tick_result_t with_typed(input tick_result_t e, input logic [3:0] code,
                                              input logic [8:0] touch, input logic ack);
    e.key_event   = (code != 0);
    e.key_code    = code;
    e.touch       = touch;
    e.ack_missing = ack;
    return e;
  endfunction

  // Key patterns: half of them one to three pressed keys, some repeats to hit held latches
  function automatic logic [15:0] key_pattern(input logic [15:0] prev);
    logic [15:0] w;
    int          pick;
    pick = $urandom_range(99);
    w    = 16'hFFFF;
    if (pick < 50)
      repeat ($urandom_range(1, 3)) w[KEY_POS[$urandom_range(KEY_COUNT - 1)]] = 1'b0;
    else if (pick < 72)
      w = prev;
    else if (pick < 82)
      w = 16'hFFFF;
    else
      w = 16'($urandom);
    return w;
  endfunction

  // Offer one tick word, idling at random, and predict it once accepted
  task automatic send_tick(input logic start_req, input logic sda_in,
                           output tick_result_t exp);
    steady = (ticks_sent >= STEADY_FROM && ticks_sent < STEADY_TO);
    while (!steady && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, sda_in, start_req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp = predict_bus_tick(start_req, sda_in);
    ticks_sent++;
  endtask

  // Run out any transfer in flight with idle ticks
  task automatic finish_transfer();
    tick_result_t exp;
    while (bus_phase != 0) begin
      send_tick(1'b0, 1'($urandom_range(1)), exp);
      bus_results_due.push_back(exp);
    end
  endtask

  // Hold the sender until every predicted word has come out
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic mode, input logic [7:0] addr);
    finish_transfer();
    wait_all_results();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_MODE;
    cfg_wdata <= {7'b0, mode};
    @(posedge clk);
    key_mode  = mode;
    cfg_index <= REG_DEV_ADDR;
    cfg_wdata <= addr;
    @(posedge clk);
    dev_addr  = addr;
    cfg_we    <= 1'b0;
  endtask

  // One full read: the device answers with ack_sda and then data, low byte first
  task automatic run_read(input logic ack_sda, input logic [15:0] data,
                          input logic start_noise, input logic typed,
                          input logic [3:0] t_code, input logic [8:0] t_touch,
                          input logic t_ack);
    tick_result_t exp;
    int           p;
    logic         s;
    logic         d;
    finish_transfer();
    for (p = PH_START; p <= PH_STOP2; p++) begin
      s = (p == PH_START) ? 1'b1 : (start_noise & 1'($urandom_range(1)));
      d = 1'($urandom_range(1));
      if (p == PH_DACK + 1)
        d = ack_sda;
      else if (p > PH_BYTE1 && p < PH_MACK && p[0])
        d = data[7 - (p - PH_BYTE1 - 1) / 2];
      else if (p > PH_BYTE2 && p < PH_NACK && p[0])
        d = data[15 - (p - PH_BYTE2 - 1) / 2];
      send_tick(s, d, exp);
      if (typed && p == PH_STOP2) exp = with_typed(exp, t_code, t_touch, t_ack);
      bus_results_due.push_back(exp);
    end
  endtask

  // Stall the output side at random, except in the steady window
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 30);
  end

  // Check every output word against the oldest prediction; count dead cycles
  always @(posedge clk) begin : check_out
    tick_result_t got;
    tick_result_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (bus_results_due.size() == 0) begin
          report_mismatch("unexpected word", got, 0);
        end else begin
          want = bus_results_due.pop_front();
          if (got.scl != want.scl) report_mismatch("scl_level", got.scl, want.scl);
          if (got.sda != want.sda) report_mismatch("sda_released", got.sda, want.sda);
          if (got.busy != want.busy) report_mismatch("busy_res", got.busy, want.busy);
          if (got.key_event != want.key_event)
            report_mismatch("key_event", got.key_event, want.key_event);
          if (got.key_code != want.key_code)
            report_mismatch("key_code", got.key_code, want.key_code);
          if (got.touch != want.touch) report_mismatch("touch_value", got.touch, want.touch);
          if (got.ack_missing != want.ack_missing)
            report_mismatch("ack_missing", got.ack_missing, want.ack_missing);
          if (got.pad != want.pad) report_mismatch("padding", got.pad, want.pad);
        end
      end
    end
  end

  // Abort when nothing moves on either side for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    tick_result_t exp;
    logic [15:0]  data;
    int           i;
    int           pick;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KEY_MODE;
    cfg_wdata <= '0;
    data = 16'hFFFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed steps
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (plan[i].set_cfg) write_regs(plan[i].mode, plan[i].addr);
      if (plan[i].kind == ROW_IDLE) begin
        send_tick(1'b0, plan[i].sda_bit, exp);
        if (plan[i].typed) exp = with_typed(exp, plan[i].t_code, plan[i].t_touch, plan[i].t_ack);
        bus_results_due.push_back(exp);
      end else begin
        run_read(plan[i].sda_bit, plan[i].data, plan[i].start_noise, plan[i].typed,
                 plan[i].t_code, plan[i].t_touch, plan[i].t_ack);
      end
    end

    // Random part: mostly well-formed reads, some stray ticks and reconfiguration
    while (ticks_sent < TOTAL_TICKS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(3))
          0:       write_regs(1'($urandom_range(1)), 8'h00);
          1:       write_regs(1'($urandom_range(1)), 8'hFF);
          default: write_regs(1'($urandom_range(1)), 8'($urandom));
        endcase
      end else if (pick < 20) begin
        // stray ticks: may launch a read from a random start request
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), exp);
          bus_results_due.push_back(exp);
        end
      end else begin
        data = key_pattern(data);
        run_read($urandom_range(99) < 15, data, 1'($urandom_range(1)),
                 1'b0, '0, '0, 1'b0);
      end
    end

    // Drain, then give the pipeline time to show a stray word
    wait_all_results();
    repeat (4) @(posedge clk);
    if (bus_results_due.size() != 0)
      report_mismatch("words never came", 0, bus_results_due.size());
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
